/* src/cht_pkg.sv */
// Package for the coalesced hash table: sizes, status codes, sequencer states
// and the request struct between the sequencer and the slot store.
// No dependencies.
package cht_pkg;

  // Table geometry. The home slot is taken as the low bits of the key,
  // so TABLE_SIZE is kept at a power of two.
  localparam int TABLE_SIZE = 32;
  localparam int IDX_W      = $clog2(TABLE_SIZE);
  localparam int KEY_W      = 31;
  localparam int STATUS_W   = 3;
  localparam int OUT_IDX_W  = 5;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd4;

  // Operation codes
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_FIND   = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_HOME,
    S_READ,
    S_CMP,
    S_PROBE,
    S_RESULT
  } cht_state_t;

  // Access request from the sequencer to the slot store
  typedef struct packed {
    logic [IDX_W-1:0] rd_addr;
    logic             fill_we;     // store key and mark slot used
    logic [IDX_W-1:0] fill_addr;
    logic [KEY_W-1:0] fill_key;
    logic             link_we;     // link chain end to the new slot
    logic [IDX_W-1:0] link_addr;
    logic [IDX_W-1:0] link_data;
  } cht_store_req_t;

endpackage

/* src/cht_if.sv */
// Valid/ready channel interfaces for request and result items.
// Depends on cht_pkg.
interface cht_in_if;
  logic                  valid;
  logic                  ready;
  logic                  operation;
  logic [cht_pkg::KEY_W-1:0] key;

  modport source (output valid, output operation, output key, input ready);
  modport sink   (input valid, input operation, input key, output ready);
endinterface

interface cht_out_if;
  logic                         valid;
  logic                         ready;
  logic [cht_pkg::STATUS_W-1:0]  status;
  logic [cht_pkg::OUT_IDX_W-1:0] slot_index;

  modport source (output valid, output status, output slot_index, input ready);
  modport sink   (input valid, input status, input slot_index, output ready);
endinterface

/* src/cht_store.sv */
// Slot store: key and link memories with registered read, plus used and
// link-valid flags in flip-flops cleared by reset. Depends on cht_pkg.
module cht_store (
  input  logic                          clk,
  input  logic                          rst_n,
  input  cht_pkg::cht_store_req_t       req,
  output logic [cht_pkg::KEY_W-1:0]     rd_key,
  output logic [cht_pkg::IDX_W-1:0]     rd_link,
  output logic [cht_pkg::TABLE_SIZE-1:0] used,
  output logic [cht_pkg::TABLE_SIZE-1:0] linked
);
  import cht_pkg::*;

  logic [KEY_W-1:0] key_mem  [TABLE_SIZE];
  logic [IDX_W-1:0] link_mem [TABLE_SIZE];
  logic [KEY_W-1:0] rd_key_r;
  logic [IDX_W-1:0] rd_link_r;
  logic [TABLE_SIZE-1:0] used_r;
  logic [TABLE_SIZE-1:0] linked_r;

  // Key memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (req.fill_we) begin
      key_mem[req.fill_addr] <= req.fill_key;
    end
    rd_key_r <= key_mem[req.rd_addr];
  end

  // Link memory: entries only meaningful where linked_r is set
  always_ff @(posedge clk) begin
    if (req.link_we) begin
      link_mem[req.link_addr] <= req.link_data;
    end
    rd_link_r <= link_mem[req.rd_addr];
  end

  // Flags, cleared at reset: every slot empty, no links
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r   <= '0;
      linked_r <= '0;
    end else begin
      if (req.fill_we) used_r[req.fill_addr] <= 1'b1;
      if (req.link_we) linked_r[req.link_addr] <= 1'b1;
    end
  end

  assign rd_key  = rd_key_r;
  assign rd_link = rd_link_r;
  assign used    = used_r;
  assign linked  = linked_r;

endmodule

/* src/coalesced_hash_table.sv */
// Top level of the coalesced hash table: request sequencer and result register.
// Depends on cht_pkg, cht_if (cht_in_if, cht_out_if) and cht_store.
//
//   channel   dir  payload                      accepted when
//   in_ch     in   operation, key               valid && ready
//   out_ch    out  status, slot_index           valid && ready
//
// One item at a time. Empty home slot: the item ends in S_HOME and the result
// is then held valid in S_RESULT until taken. Otherwise each chain slot
// visited takes a key/link memory read (S_READ) and a compare (S_CMP), then an
// insert probes slot by slot in S_PROBE for a free one (up to 31).
// Synchronous active-low reset clears the used and link flags at once.
// in_ch.ready is low during reset and from accept until the result item is
// taken on out_ch.
module coalesced_hash_table (
  input  logic     clk,
  input  logic     rst_n,
  cht_in_if.sink   in_ch,
  cht_out_if.source out_ch
);
  import cht_pkg::*;

  cht_state_t        state_r, state_nxt;
  logic              op_r, op_nxt;
  logic [KEY_W-1:0]  key_r, key_nxt;
  logic [IDX_W-1:0]  cur_r, cur_nxt;     // chain walk slot / chain end
  logic [IDX_W-1:0]  cand_r, cand_nxt;   // probe candidate
  logic [IDX_W-1:0]  cnt_r, cnt_nxt;     // probe count
  logic [STATUS_W-1:0]  status_r, status_nxt;
  logic [OUT_IDX_W-1:0] index_r, index_nxt;

  cht_store_req_t        req;
  logic [KEY_W-1:0]      rd_key;
  logic [IDX_W-1:0]      rd_link;
  logic [TABLE_SIZE-1:0] used;
  logic [TABLE_SIZE-1:0] linked;

  cht_store u_store (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (req),
    .rd_key (rd_key),
    .rd_link(rd_link),
    .used   (used),
    .linked (linked)
  );

  // State and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    key_r    <= key_nxt;
    cur_r    <= cur_nxt;
    cand_r   <= cand_nxt;
    cnt_r    <= cnt_nxt;
    status_r <= status_nxt;
    index_r  <= index_nxt;
  end

  // Sequencer
  always_comb begin
    state_nxt  = state_r;
    op_nxt     = op_r;
    key_nxt    = key_r;
    cur_nxt    = cur_r;
    cand_nxt   = cand_r;
    cnt_nxt    = cnt_r;
    status_nxt = status_r;
    index_nxt  = index_r;

    req           = '0;
    req.rd_addr   = cur_r;
    req.fill_addr = cur_r;
    req.fill_key  = key_r;
    req.link_addr = cur_r;
    req.link_data = cand_r;

    in_ch.ready  = 1'b0;
    out_ch.valid = 1'b0;

    case (state_r)
      S_IDLE: begin
        in_ch.ready = rst_n;
        if (in_ch.valid) begin
          op_nxt    = in_ch.operation;
          key_nxt   = in_ch.key;
          cur_nxt   = in_ch.key[IDX_W-1:0];  // key mod TABLE_SIZE
          state_nxt = S_HOME;
        end
      end

      // Empty home slot ends the item at once
      S_HOME: begin
        if (!used[cur_r]) begin
          if (op_r == OP_FIND) begin
            status_nxt = ST_NOT_FOUND;
            index_nxt  = '0;
          end else begin
            req.fill_we = 1'b1;
            status_nxt  = ST_INSERTED;
            index_nxt   = OUT_IDX_W'(cur_r);
          end
          state_nxt = S_RESULT;
        end else begin
          state_nxt = S_READ;
        end
      end

      // Memory read of cur_r is in flight
      S_READ: begin
        state_nxt = S_CMP;
      end

      S_CMP: begin
        if (rd_key == key_r) begin
          if (op_r == OP_FIND) begin
            status_nxt = ST_FOUND;
            index_nxt  = OUT_IDX_W'(cur_r);
          end else begin
            status_nxt = ST_DUPLICATE;
            index_nxt  = '0;
          end
          state_nxt = S_RESULT;
        end else if (linked[cur_r]) begin
          cur_nxt   = rd_link;
          state_nxt = S_READ;
        end else if (op_r == OP_FIND) begin
          status_nxt = ST_NOT_FOUND;
          index_nxt  = '0;
          state_nxt  = S_RESULT;
        end else begin
          // chain end reached: probe forward with wraparound
          cand_nxt  = cur_r + 1'b1;
          cnt_nxt   = IDX_W'(1);
          state_nxt = S_PROBE;
        end
      end

      S_PROBE: begin
        if (!used[cand_r]) begin
          req.fill_we   = 1'b1;
          req.fill_addr = cand_r;
          req.link_we   = 1'b1;
          status_nxt    = ST_INSERTED;
          index_nxt     = OUT_IDX_W'(cand_r);
          state_nxt     = S_RESULT;
        end else if (cnt_r == IDX_W'(TABLE_SIZE - 1)) begin
          status_nxt = ST_FULL;
          index_nxt  = '0;
          state_nxt  = S_RESULT;
        end else begin
          cand_nxt = cand_r + 1'b1;
          cnt_nxt  = cnt_r + 1'b1;
        end
      end

      S_RESULT: begin
        out_ch.valid = 1'b1;
        if (out_ch.ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_ch.status     = status_r;
  assign out_ch.slot_index = index_r;

endmodule

/* tb/cht_sb_pkg.sv */
`timescale 1ns / 100ps
// Scoreboard for the coalesced hash table: a mirror of the slot store that
// predicts each reply, and the queue of replies still owed. Depends on cht_pkg.
package cht_sb_pkg;
  import cht_pkg::*;

  typedef struct packed {
    logic [STATUS_W-1:0]  status;
    logic [OUT_IDX_W-1:0] slot_index;
  } cht_reply_t;

  class cht_scoreboard;
    logic [KEY_W-1:0] mirror_key  [TABLE_SIZE];
    bit               mirror_used [TABLE_SIZE];
    int               mirror_link [TABLE_SIZE];  // negative: end of chain
    cht_reply_t       predicted_replies [$];
    int               errors;

    function new();
      errors = 0;
      for (int i = 0; i < TABLE_SIZE; i++) begin
        mirror_key[i]  = '0;
        mirror_used[i] = 1'b0;
        mirror_link[i] = -1;
      end
    endfunction

    // Follow the chain from slot. Returns 1 with slot on the match, or 0 with
    // slot left at the chain end. The walk is bounded by the table size.
    function bit walk_chain(logic [KEY_W-1:0] key, inout int unsigned slot);
      for (int n = 0; n < TABLE_SIZE; n++) begin
        if (mirror_key[slot] == key) return 1'b1;
        if (mirror_link[slot] < 0) return 1'b0;
        slot = mirror_link[slot];
      end
      return 1'b0;
    endfunction

    // Accepted request: update the mirror and queue the reply it must cause
    function void note_request(logic op, logic [KEY_W-1:0] key);
      int unsigned slot;
      int unsigned cand;
      cht_reply_t  reply;
      slot = key % TABLE_SIZE;
      reply.status     = ST_NOT_FOUND;
      reply.slot_index = '0;
      if (op == OP_FIND) begin
        if (mirror_used[slot] && walk_chain(key, slot)) begin
          reply.status     = ST_FOUND;
          reply.slot_index = OUT_IDX_W'(slot);
        end
      end else if (!mirror_used[slot]) begin
        mirror_used[slot] = 1'b1;
        mirror_key[slot]  = key;
        reply.status      = ST_INSERTED;
        reply.slot_index  = OUT_IDX_W'(slot);
      end else if (walk_chain(key, slot)) begin
        reply.status = ST_DUPLICATE;
      end else begin
        // linear probe past the chain end, wrapping around
        reply.status = ST_FULL;
        for (int k = 1; k < TABLE_SIZE; k++) begin
          cand = (slot + k) % TABLE_SIZE;
          if (!mirror_used[cand]) begin
            mirror_used[cand] = 1'b1;
            mirror_key[cand]  = key;
            mirror_link[slot] = cand;
            reply.status      = ST_INSERTED;
            reply.slot_index  = OUT_IDX_W'(cand);
            break;
          end
        end
      end
      predicted_replies.push_back(reply);
    endfunction

    function int pending();
      return predicted_replies.size();
    endfunction

    task report(string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      errors++;
    endtask

    // Accepted reply: compare with the oldest prediction
    task check_result(logic [STATUS_W-1:0] status, logic [OUT_IDX_W-1:0] slot_index);
      cht_reply_t want;
      if (predicted_replies.size() == 0) begin
        report($sformatf("reply with none pending: status %0d slot %0d",
                         status, slot_index));
        return;
      end
      want = predicted_replies.pop_front();
      if (status !== want.status)
        report($sformatf("status %0d, predicted %0d", status, want.status));
      if (slot_index !== want.slot_index)
        report($sformatf("slot_index %0d, predicted %0d", slot_index, want.slot_index));
    endtask
  endclass

endpackage

/* tb/tb_top.sv */
`timescale 1ns / 100ps
// Top of the coalesced hash table testbench: clock, reset, request driver,
// reply sink with stalls, and watchdog. Depends on cht_pkg, cht_if, cht_sb_pkg.
module tb_top;
  import cht_pkg::*;
  import cht_sb_pkg::*;

  localparam int RANDOM_ITEMS     = 1500;
  localparam int QUIET_ITEMS      = 200;
  localparam int PAUSE_AT         = 700;
  localparam int LONG_HOLD_AT     = 300;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES     = 200;
  localparam int WATCHDOG_LIMIT   = 5000;

  logic clk;
  logic rst_n;

  cht_in_if  in_if ();
  cht_out_if out_if ();

  coalesced_hash_table u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  cht_scoreboard    sb;
  logic [KEY_W-1:0] inserted_keys [$];
  bit               quiet_phase = 1'b0;
  int               results_seen = 0;
  int               idle_cycles = 0;

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Key with random upper bits and a home slot biased to a few slots,
  // so chains grow long and coalesce
  function automatic logic [KEY_W-1:0] chain_key();
    logic [KEY_W-1:0] k;
    k = KEY_W'($urandom());
    if ($urandom_range(0, 9) < 7) k[4:0] = 5'($urandom_range(0, 7));
    return k;
  endfunction

  function automatic logic [KEY_W-1:0] known_key();
    return inserted_keys[$urandom_range(0, inserted_keys.size() - 1)];
  endfunction

  // Offer one request and wait for it to be taken; then either drop valid
  // (stop_after) or maybe idle for a random burst
  task automatic send_request(input logic op, input logic [KEY_W-1:0] key,
                              input bit stop_after);
    in_if.valid     <= 1'b1;
    in_if.operation <= op;
    in_if.key       <= key;
    do @(posedge clk); while (!in_if.ready);
    sb.note_request(op, key);
    if (op == OP_INSERT) inserted_keys.push_back(key);
    if (stop_after) begin
      in_if.valid <= 1'b0;
    end else if (!quiet_phase && $urandom_range(0, 5) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
  endtask

  // Request side
  initial begin
    logic             op;
    logic [KEY_W-1:0] key;
    int               pick;
    sb = new();
    in_if.valid     <= 1'b0;
    in_if.operation <= OP_INSERT;
    in_if.key       <= '0;
    rst_n           <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty table, extreme keys, collisions, wraparound probe,
    // a chain that runs through another key's home slot, duplicates, misses
    send_request(OP_FIND,   31'd0,          1'b0);
    send_request(OP_INSERT, 31'd0,          1'b0);
    send_request(OP_INSERT, 31'h7FFF_FFFF,  1'b0);
    send_request(OP_FIND,   31'd0,          1'b0);
    send_request(OP_INSERT, 31'd32,         1'b0);
    send_request(OP_INSERT, 31'd63,         1'b0);
    send_request(OP_INSERT, 31'd1,          1'b0);
    send_request(OP_FIND,   31'd1,          1'b0);
    send_request(OP_FIND,   31'd32,         1'b0);
    send_request(OP_FIND,   31'd63,         1'b0);
    send_request(OP_FIND,   31'h7FFF_FFFF,  1'b0);
    send_request(OP_INSERT, 31'd32,         1'b0);
    send_request(OP_INSERT, 31'h7FFF_FFFF,  1'b0);
    send_request(OP_FIND,   31'd65,         1'b0);
    send_request(OP_FIND,   31'h7FFF_FFE0,  1'b0);
    send_request(OP_FIND,   31'd2,          1'b0);
    send_request(OP_INSERT, 31'h5555_5555,  1'b0);
    send_request(OP_INSERT, 31'h2AAA_AAAA,  1'b0);
    send_request(OP_FIND,   31'h5555_5555,  1'b0);
    send_request(OP_FIND,   31'h2AAA_AAAA,  1'b0);

    // Random: mostly finds and duplicate inserts; new keys trickle in so the
    // table fills partway through and the full case is hit many times
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      quiet_phase = (i >= RANDOM_ITEMS - QUIET_ITEMS);
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
        op  = OP_INSERT;
        key = chain_key();
      end else if (pick < 13) begin
        op  = OP_INSERT;
        key = known_key();
      end else if (pick < 53) begin
        op  = OP_FIND;
        key = known_key();
      end else if (pick < 83) begin
        op  = OP_FIND;
        key = chain_key();
      end else begin
        op  = ($urandom_range(0, 15) == 0) ? OP_INSERT : OP_FIND;
        key = KEY_W'($urandom());
      end
      send_request(op, key, (i == PAUSE_AT) || (i == RANDOM_ITEMS - 1));
      // sender pause: let every reply drain
      if (i == PAUSE_AT)
        while (sb.pending() != 0) @(posedge clk);
    end

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.pending() != 0)
      sb.report($sformatf("%0d replies never arrived", sb.pending()));
    if (sb.errors == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

  // Reply side: random stall bursts, one long hold-off so the block backs up
  initial begin
    int sink_stall;
    bit long_hold_done;
    sink_stall     = 0;
    long_hold_done = 1'b0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_if.valid && out_if.ready) begin
        sb.check_result(out_if.status, out_if.slot_index);
        results_seen++;
      end
      if (!long_hold_done && results_seen >= LONG_HOLD_AT) begin
        sink_stall     = LONG_HOLD_CYCLES;
        long_hold_done = 1'b1;
      end else if (sink_stall == 0 && !quiet_phase && $urandom_range(0, 7) == 0) begin
        sink_stall = $urandom_range(1, 11);
      end
      out_if.ready <= (sink_stall == 0);
      if (sink_stall > 0) sink_stall--;
    end
  end

  // Watchdog: cycles without any item moving on either channel
  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TIMEOUT: no item moved for %0d cycles", WATCHDOG_LIMIT);
      $display("Test completed with failures");
      $finish;
    end
  end

endmodule

/* coalesced_hash_table.f */
src/cht_pkg.sv
src/cht_if.sv
src/cht_store.sv
src/coalesced_hash_table.sv
tb/cht_sb_pkg.sv
tb/tb_top.sv
